### src/tlswm_pkg.sv
package tlswm_pkg;

  localparam int INDEX_W = 20;
  localparam int VALUE_W = 32;

  localparam int TOP_BITS_DEF   = 10;
  localparam int PAGE_BITS_DEF  = 10;
  localparam int POOL_PAGES_DEF = 16;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_SCAN,
    ST_WORD,
    ST_DONE
  } state_e;

endpackage

### src/tlswm_ram.sv
module tlswm_ram #(
  parameter int AW = 4,
  parameter int W  = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [2**AW];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/tlswm_ctrl.sv
module tlswm_ctrl
  import tlswm_pkg::*;
#(
  parameter int TOP_BITS   = TOP_BITS_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int POOL_PAGES = POOL_PAGES_DEF,
  localparam int PG_W      = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1,
  localparam int PM_W      = PG_W + 1,
  localparam int WS_AW     = PG_W + PAGE_BITS,
  localparam int CNT_W     = PAGE_BITS + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [INDEX_W-1:0]   index_i,
  input  logic [VALUE_W-1:0]   value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [VALUE_W-1:0]   read_value_o,
  output logic                 status_o,
  output logic                 pm_we_o,
  output logic [TOP_BITS-1:0]  pm_waddr_o,
  output logic [PM_W-1:0]      pm_wdata_o,
  output logic                 pm_re_o,
  output logic [TOP_BITS-1:0]  pm_raddr_o,
  input  logic [PM_W-1:0]      pm_rdata_i,
  output logic                 ws_we_o,
  output logic [WS_AW-1:0]     ws_waddr_o,
  output logic [VALUE_W-1:0]   ws_wdata_o,
  output logic                 ws_re_o,
  output logic [WS_AW-1:0]     ws_raddr_o,
  input  logic [VALUE_W-1:0]   ws_rdata_i,
  output logic                 cnt_we_o,
  output logic [PG_W-1:0]      cnt_waddr_o,
  output logic [CNT_W-1:0]     cnt_wdata_o,
  output logic                 cnt_re_o,
  output logic [PG_W-1:0]      cnt_raddr_o,
  input  logic [CNT_W-1:0]     cnt_rdata_i
);

  localparam int TOP_ENTRIES = 2 ** TOP_BITS;
  localparam int WS_DEPTH    = POOL_PAGES * (2 ** PAGE_BITS);
  localparam int CLR_LEN     = (TOP_ENTRIES > WS_DEPTH) ? TOP_ENTRIES : WS_DEPTH;
  localparam int CLR_W       = $clog2(CLR_LEN);

  state_e state_q, state_d;

  logic [CLR_W-1:0]      clr_q, clr_d;
  logic [PG_W-1:0]       scan_q, scan_d;
  logic [PG_W-1:0]       page_q, page_d;
  logic [POOL_PAGES-1:0] live_q, live_d;
  logic                  out_valid_q, out_valid_d;

  logic                  op_q, op_d;
  logic [TOP_BITS-1:0]   top_q, top_d;
  logic [PAGE_BITS-1:0]  bot_q, bot_d;
  logic [VALUE_W-1:0]    val_q, val_d;
  logic [VALUE_W-1:0]    res_rd_q, res_rd_d;
  logic                  res_st_q, res_st_d;
  logic [VALUE_W-1:0]    out_rd_q, out_rd_d;
  logic                  out_st_q, out_st_d;

  logic [INDEX_W+16-1:0] idx_sh;
  logic [TOP_BITS-1:0]   top_in;
  logic                  map_v;
  logic [PG_W-1:0]       map_pg;
  logic                  wr_nz;
  logic                  scan_busy;
  logic                  scan_last;
  logic                  clr_last;
  logic                  clr_pm;
  logic                  clr_ws;
  logic                  out_free;
  logic [CNT_W-1:0]      cnt_cur;
  logic [CNT_W-1:0]      cnt_dec;
  logic [CNT_W-1:0]      cnt_inc;

  assign idx_sh    = {16'b0, index_i} >> PAGE_BITS;
  assign top_in    = idx_sh[TOP_BITS-1:0];
  assign map_v     = pm_rdata_i[PM_W-1];
  assign map_pg    = pm_rdata_i[PG_W-1:0];
  assign wr_nz     = (op_q == OP_WRITE) && (val_q != '0);
  assign scan_busy = live_q[scan_q];
  assign scan_last = (scan_q == PG_W'(POOL_PAGES - 1));
  assign clr_last  = (clr_q == CLR_W'(CLR_LEN - 1));
  assign clr_pm    = ({1'b0, clr_q} < (CLR_W+1)'(TOP_ENTRIES));
  assign clr_ws    = ({1'b0, clr_q} < (CLR_W+1)'(WS_DEPTH));
  assign out_free  = !out_valid_q || !out_stall_i;

  // a page whose live flag is clear has a zero count, whatever the memory holds
  assign cnt_cur = live_q[page_q] ? cnt_rdata_i : '0;
  assign cnt_dec = (cnt_cur != '0) ? cnt_cur - CNT_W'(1) : '0;
  assign cnt_inc = cnt_cur + CNT_W'(1);

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_rd_q;
  assign status_o     = out_st_q;

  always_comb begin : next_state
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MAP;
      end
      ST_MAP: begin
        if (map_v) state_d = ST_WORD;
        else if (wr_nz) state_d = ST_SCAN;
        else state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (!scan_busy) state_d = ST_WORD;
        else if (scan_last) state_d = ST_DONE;
      end
      ST_WORD: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin : outputs
    clr_d       = clr_q;
    scan_d      = scan_q;
    page_d      = page_q;
    live_d      = live_q;
    op_d        = op_q;
    top_d       = top_q;
    bot_d       = bot_q;
    val_d       = val_q;
    res_rd_d    = res_rd_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rd_d    = out_rd_q;
    out_st_d    = out_st_q;

    pm_we_o     = 1'b0;
    pm_waddr_o  = top_q;
    pm_wdata_o  = '0;
    pm_re_o     = 1'b0;
    pm_raddr_o  = top_in;
    ws_we_o     = 1'b0;
    ws_waddr_o  = {page_q, bot_q};
    ws_wdata_o  = '0;
    ws_re_o     = 1'b0;
    ws_raddr_o  = {map_pg, bot_q};
    cnt_we_o    = 1'b0;
    cnt_waddr_o = page_q;
    cnt_wdata_o = cnt_cur;
    cnt_re_o    = 1'b0;
    cnt_raddr_o = map_pg;

    unique case (state_q)
      ST_CLEAR: begin
        clr_d      = clr_q + CLR_W'(1);
        pm_we_o    = clr_pm;
        pm_waddr_o = TOP_BITS'(clr_q);
        ws_we_o    = clr_ws;
        ws_waddr_o = WS_AW'(clr_q);
      end
      ST_IDLE: begin
        pm_re_o = in_valid_i;
        op_d    = op_i;
        top_d   = top_in;
        bot_d   = index_i[PAGE_BITS-1:0];
        val_d   = value_i;
      end
      ST_MAP: begin
        res_rd_d = '0;
        res_st_d = STATUS_OK;
        scan_d   = '0;
        page_d   = map_pg;
        ws_re_o  = map_v;
        cnt_re_o = map_v;
      end
      ST_SCAN: begin
        if (!scan_busy) begin
          page_d      = scan_q;
          pm_we_o     = 1'b1;
          pm_wdata_o  = {1'b1, scan_q};
          ws_re_o     = 1'b1;
          ws_raddr_o  = {scan_q, bot_q};
          cnt_re_o    = 1'b1;
          cnt_raddr_o = scan_q;
        end else if (scan_last) begin
          res_st_d = STATUS_FULL;
        end else begin
          scan_d = scan_q + PG_W'(1);
        end
      end
      ST_WORD: begin
        if (op_q == OP_READ) begin
          res_rd_d = ws_rdata_i;
        end else if (val_q == '0) begin
          if (ws_rdata_i != '0) begin
            ws_we_o     = 1'b1;
            cnt_we_o    = 1'b1;
            cnt_wdata_o = cnt_dec;
            // last live word gone: page goes back to the pool
            if (cnt_dec == '0) begin
              live_d[page_q] = 1'b0;
              pm_we_o        = 1'b1;
            end
          end
        end else begin
          ws_we_o    = 1'b1;
          ws_wdata_o = val_q;
          if (ws_rdata_i == '0) begin
            cnt_we_o       = 1'b1;
            cnt_wdata_o    = cnt_inc;
            live_d[page_q] = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rd_d    = res_rd_q;
          out_st_d    = res_st_q;
        end
      end
      default: begin
        clr_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      scan_q      <= '0;
      page_q      <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      scan_q      <= scan_d;
      page_q      <= page_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    top_q    <= top_d;
    bot_q    <= bot_d;
    val_q    <= val_d;
    res_rd_q <= res_rd_d;
    res_st_q <= res_st_d;
    out_rd_q <= out_rd_d;
    out_st_q <= out_st_d;
  end

  // a nonzero write leaves its page live
  a_live_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WORD && wr_nz) |=> live_q[$past(page_q)])
    else $error("page not live after nonzero write");

  // clearing a stored word means its page already holds a live count
  a_clear_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WORD && op_q == OP_WRITE && val_q == '0 && ws_rdata_i != '0)
      |-> live_q[page_q])
    else $error("nonzero word found in a page with no live count");

  a_ws_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ws_we_o |-> (state_q == ST_CLEAR || state_q == ST_WORD))
    else $error("word store written outside clear or update");

  // a finished result is never dropped while the output is stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_free) |=> (state_q == ST_DONE && out_valid_q))
    else $error("pending result lost");

endmodule

### src/two_level_sparse_word_map.sv
// Sparse map from a 20-bit index to a 32-bit word (zero means absent). The index bits above
// PAGE_BITS pick a page map entry, the low PAGE_BITS pick a word in a pool page; pages are
// taken from a pool of POOL_PAGES on the first nonzero write and go back when their last
// nonzero word is cleared. A write that needs a page while the pool is full is dropped and
// returns status 1. One item is handled at a time by a small sequencer over three synchronous
// memories (page map, word store, live counts): a read or clear on an unmapped page goes from
// the page map lookup straight to the result, a mapped access reads its word before the result,
// and an allocating write first scans the pool pages for the lowest free one; a write
// dropped on a full pool scans every pool page. After reset a clearing pass walks
// max(2**TOP_BITS, POOL_PAGES * 2**PAGE_BITS) addresses (16384 at the defaults) before
// the first beat is taken.
module two_level_sparse_word_map
  import tlswm_pkg::*;
#(
  parameter int TOP_BITS   = TOP_BITS_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int POOL_PAGES = POOL_PAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [INDEX_W-1:0] index_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [VALUE_W-1:0] read_value_o,
  output logic               status_o
);

  localparam int PG_W  = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int PM_W  = PG_W + 1;
  localparam int WS_AW = PG_W + PAGE_BITS;
  localparam int CNT_W = PAGE_BITS + 1;

  logic                pm_we;
  logic [TOP_BITS-1:0] pm_waddr;
  logic [PM_W-1:0]     pm_wdata;
  logic                pm_re;
  logic [TOP_BITS-1:0] pm_raddr;
  logic [PM_W-1:0]     pm_rdata;
  logic                ws_we;
  logic [WS_AW-1:0]    ws_waddr;
  logic [VALUE_W-1:0]  ws_wdata;
  logic                ws_re;
  logic [WS_AW-1:0]    ws_raddr;
  logic [VALUE_W-1:0]  ws_rdata;
  logic                cnt_we;
  logic [PG_W-1:0]     cnt_waddr;
  logic [CNT_W-1:0]    cnt_wdata;
  logic                cnt_re;
  logic [PG_W-1:0]     cnt_raddr;
  logic [CNT_W-1:0]    cnt_rdata;

  tlswm_ctrl #(
    .TOP_BITS  (TOP_BITS),
    .PAGE_BITS (PAGE_BITS),
    .POOL_PAGES(POOL_PAGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_value_o(read_value_o),
    .status_o    (status_o),
    .pm_we_o     (pm_we),
    .pm_waddr_o  (pm_waddr),
    .pm_wdata_o  (pm_wdata),
    .pm_re_o     (pm_re),
    .pm_raddr_o  (pm_raddr),
    .pm_rdata_i  (pm_rdata),
    .ws_we_o     (ws_we),
    .ws_waddr_o  (ws_waddr),
    .ws_wdata_o  (ws_wdata),
    .ws_re_o     (ws_re),
    .ws_raddr_o  (ws_raddr),
    .ws_rdata_i  (ws_rdata),
    .cnt_we_o    (cnt_we),
    .cnt_waddr_o (cnt_waddr),
    .cnt_wdata_o (cnt_wdata),
    .cnt_re_o    (cnt_re),
    .cnt_raddr_o (cnt_raddr),
    .cnt_rdata_i (cnt_rdata)
  );

  // page map entry: valid bit over pool page number
  tlswm_ram #(
    .AW(TOP_BITS),
    .W (PM_W)
  ) u_page_map (
    .clk_i  (clk_i),
    .we_i   (pm_we),
    .waddr_i(pm_waddr),
    .wdata_i(pm_wdata),
    .re_i   (pm_re),
    .raddr_i(pm_raddr),
    .rdata_o(pm_rdata)
  );

  tlswm_ram #(
    .AW(WS_AW),
    .W (VALUE_W)
  ) u_word_store (
    .clk_i  (clk_i),
    .we_i   (ws_we),
    .waddr_i(ws_waddr),
    .wdata_i(ws_wdata),
    .re_i   (ws_re),
    .raddr_i(ws_raddr),
    .rdata_o(ws_rdata)
  );

  tlswm_ram #(
    .AW(PG_W),
    .W (CNT_W)
  ) u_live_count (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .re_i   (cnt_re),
    .raddr_i(cnt_raddr),
    .rdata_o(cnt_rdata)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tlswm_pkg::*;

  localparam int TOP_N          = 1 << TOP_BITS_DEF;
  localparam int PAGE_N         = 1 << PAGE_BITS_DEF;
  localparam int POOL_N         = POOL_PAGES_DEF;
  localparam int PAGE_ID_W      = $clog2(POOL_PAGES_DEF);
  localparam int HALF_PERIOD_NS = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int ITEM_TARGET    = 1850;
  localparam int HOT_TOPS       = 24;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 300;
  localparam int LIMIT_CYCLES   = 1_000_000;
  localparam int PRINT_LIMIT    = 50;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               status;
  } map_reply_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  class sparse_map_scoreboard;
    bit                 page_valid [TOP_N];
    bit [PAGE_ID_W-1:0] page_of    [TOP_N];
    int unsigned        live_words [POOL_N];
    bit [VALUE_W-1:0]   word_store [POOL_N * PAGE_N];
    map_reply_t         pending_replies [$];
    int unsigned        mismatches;

    // track the map after one accepted access and queue the reply it should give
    function void note_access(logic op, logic [INDEX_W-1:0] index, logic [VALUE_W-1:0] value);
      int unsigned top;
      int unsigned bottom;
      int unsigned page;
      int unsigned slot;
      bit          found;
      map_reply_t  reply;
      top    = index[PAGE_BITS_DEF +: TOP_BITS_DEF];
      bottom = index[PAGE_BITS_DEF-1:0];
      reply.read_value = '0;
      reply.status     = STATUS_OK;
      if (op == OP_READ) begin
        if (page_valid[top]) begin
          page = page_of[top];
          reply.read_value = word_store[page * PAGE_N + bottom];
        end
      end else if (value == '0) begin
        if (page_valid[top]) begin
          page = page_of[top];
          slot = page * PAGE_N + bottom;
          if (word_store[slot] != '0) begin
            word_store[slot] = '0;
            if (live_words[page] > 0) live_words[page]--;
            // last live word gone: page goes back to the pool
            if (live_words[page] == 0) page_valid[top] = 1'b0;
          end
        end
      end else begin
        found = page_valid[top];
        page  = page_of[top];
        // lowest free pool page
        for (int i = 0; i < POOL_N && !found; i++) begin
          if (live_words[i] == 0) begin
            found           = 1'b1;
            page            = i;
            page_valid[top] = 1'b1;
            page_of[top]    = PAGE_ID_W'(i);
          end
        end
        if (!found) begin
          reply.status = STATUS_FULL;
        end else begin
          slot = page * PAGE_N + bottom;
          if (word_store[slot] == '0) live_words[page]++;
          word_store[slot] = value;
        end
      end
      pending_replies.push_back(reply);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_reply(logic [VALUE_W-1:0] read_value, logic status);
      map_reply_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply with nothing pending: read_value=%h status=%b",
                                  read_value, status));
      end else begin
        want = pending_replies.pop_front();
        if (read_value !== want.read_value)
          report_mismatch($sformatf("read_value %h, want %h", read_value, want.read_value));
        if (status !== want.status)
          report_mismatch($sformatf("status %b, want %b", status, want.status));
      end
    endtask
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic               op_i        = OP_READ;
  logic [INDEX_W-1:0] index_i     = '0;
  logic [VALUE_W-1:0] value_i     = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [VALUE_W-1:0] read_value_o;
  logic               status_o;

  sparse_map_scoreboard scoreboard = new;

  int unsigned items_sent = 0;
  int          burst_left = 20;

  logic [PAGE_BITS_DEF-1:0] hot_bottoms [3] = '{10'h000, 10'h3ff, 10'h2a5};

  two_level_sparse_word_map dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_value_o(read_value_o),
    .status_o    (status_o)
  );

  always #HALF_PERIOD_NS clk_i = ~clk_i;

  // offer one beat, hold it until taken, then maybe close the burst with a gap
  task automatic send_beat(logic op, logic [INDEX_W-1:0] index, logic [VALUE_W-1:0] value);
    int unsigned gap;
    op_i       <= op;
    index_i    <= index;
    value_i    <= value;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    scoreboard.note_access(op, index, value);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 60);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (scoreboard.pending_replies.size() != 0);
  endtask

  initial begin : stimulus
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    int unsigned        pick;
    bit                 paused;
    paused = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(OP_READ, '0, $urandom);
    send_beat(OP_WRITE, 20'h00005, '0);         // clear on an unmapped page
    send_beat(OP_WRITE, '1, '1);
    send_beat(OP_WRITE, '1, 32'h0000_0001);     // overwrite, count stays
    send_beat(OP_WRITE, 20'hffc00, '0);         // clear of a word already zero
    send_beat(OP_WRITE, '1, '0);                // last word cleared, page freed
    for (int t = 0; t < POOL_N; t++)
      send_beat(OP_WRITE, INDEX_W'(t << PAGE_BITS_DEF), VALUE_W'(t + 1));
    index = INDEX_W'((POOL_N << PAGE_BITS_DEF) | 10'h3ff);
    send_beat(OP_WRITE, index, 32'h8000_0000);  // pool exhausted, dropped
    send_beat(OP_READ, index, '0);
    send_beat(OP_WRITE, INDEX_W'(3 << PAGE_BITS_DEF), '0);
    send_beat(OP_WRITE, index, 32'h7fff_ffff);  // takes the freed page
    send_beat(OP_READ, index, '0);

    while (items_sent < ITEM_TARGET) begin
      if (!paused && items_sent >= ITEM_TARGET / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        // small hot set of pages so the pool fills and drains again
        index = INDEX_W'(($urandom_range(0, HOT_TOPS - 1) << PAGE_BITS_DEF)
                         | hot_bottoms[$urandom_range(0, 2)]);
        if ($urandom_range(0, 2) == 0) begin
          send_beat(OP_READ, index, $urandom);
        end else begin
          value = ($urandom_range(0, 99) < 55) ? '0 : $urandom;
          send_beat(OP_WRITE, index, value);
        end
      end else if (pick < 90) begin
        // write anywhere, read back, clear so no stray page is left behind
        index = INDEX_W'($urandom);
        value = $urandom;
        if (value == '0) value = 32'h1;
        send_beat(OP_WRITE, index, value);
        send_beat(OP_READ, index, $urandom);
        send_beat(OP_WRITE, index, '0);
      end else if (pick < 96) begin
        send_beat(OP_READ, INDEX_W'($urandom), $urandom);
      end else begin
        send_beat(OP_WRITE, INDEX_W'($urandom), '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (scoreboard.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned replies_seen;
    int unsigned cycle_count;
    int unsigned hold_left;
    bit          held;
    bit          stall;
    stall_mode_e mode;
    replies_seen = 0;
    cycle_count  = 0;
    hold_left    = 0;
    held         = 1'b0;
    mode         = STALL_NONE;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        scoreboard.check_reply(read_value_o, status_o);
        replies_seen++;
      end
      cycle_count++;
      if (cycle_count % 256 == 0) mode = stall_mode_e'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (!held && replies_seen >= HOLD_AFTER) begin
        // long hold-off while the sender keeps offering
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        stall     = 1'b1;
      end else begin
        case (mode)
          STALL_NONE:  stall = 1'b0;
          STALL_LIGHT: stall = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: stall = ($urandom_range(0, 3) != 0);
          default:     stall = ((cycle_count % 7) < 3);
        endcase
      end
      out_stall_i <= stall;
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

endmodule
